/* rtl/clws_pkg.sv */
package clws_pkg;

  localparam int PC_W = 4;

  typedef logic [PC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    OP_COMMAND = 3'd0,
    OP_CHAR    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_CURSOR  = 3'd3,
    OP_NUMBER  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    A_FETCH,
    A_LD_CMD,
    A_LD_CHR,
    A_LD_CLR,
    A_LD_CUR,
    A_LD_NUM,
    A_DIV,
    A_PUSH,
    A_POP,
    A_EMIT_HI,
    A_EMIT_LO
  } action_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_DIV_MORE,
    C_DIGIT_MORE,
    C_RETURN
  } cond_t;

  typedef struct packed {
    action_t act;
    cond_t   cond;
    upc_t    target;
  } uword_t;

  // microprogram addresses
  localparam upc_t U_FETCH   = 4'd0;
  localparam upc_t U_CMD     = 4'd1;
  localparam upc_t U_CHR     = 4'd2;
  localparam upc_t U_CLR     = 4'd3;
  localparam upc_t U_CUR     = 4'd4;
  localparam upc_t U_NUM     = 4'd5;
  localparam upc_t U_DIV     = 4'd6;
  localparam upc_t U_PUSH    = 4'd7;
  localparam upc_t U_POP     = 4'd8;
  localparam upc_t U_SEND    = 4'd9;
  localparam upc_t U_SEND_LO = 4'd10;

  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] ADDR_ROW1  = 8'h80;
  localparam logic [7:0] ADDR_ROW2  = 8'hC0;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] LAST_COL   = 8'd16;
  localparam logic [4:0] RADIX      = 5'd10;

  localparam logic [3:0] WAIT_STROBE      = 4'd2;
  localparam logic [3:0] WAIT_BYTE        = 4'd3;
  localparam logic [3:0] WAIT_CLEAR_EXTRA = 4'd10;
  localparam logic [3:0] WAIT_CLEAR_LAST  = WAIT_BYTE + WAIT_CLEAR_EXTRA;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      U_FETCH:   w = '{act: A_FETCH,   cond: C_DISPATCH,   target: U_FETCH};
      U_CMD:     w = '{act: A_LD_CMD,  cond: C_JUMP,       target: U_SEND};
      U_CHR:     w = '{act: A_LD_CHR,  cond: C_JUMP,       target: U_SEND};
      U_CLR:     w = '{act: A_LD_CLR,  cond: C_JUMP,       target: U_SEND};
      U_CUR:     w = '{act: A_LD_CUR,  cond: C_JUMP,       target: U_SEND};
      U_NUM:     w = '{act: A_LD_NUM,  cond: C_NEXT,       target: U_FETCH};
      U_DIV:     w = '{act: A_DIV,     cond: C_DIV_MORE,   target: U_DIV};
      U_PUSH:    w = '{act: A_PUSH,    cond: C_DIGIT_MORE, target: U_DIV};
      U_POP:     w = '{act: A_POP,     cond: C_NEXT,       target: U_FETCH};
      U_SEND:    w = '{act: A_EMIT_HI, cond: C_NEXT,       target: U_FETCH};
      U_SEND_LO: w = '{act: A_EMIT_LO, cond: C_RETURN,     target: U_POP};
      default:   w = '{act: A_FETCH,   cond: C_JUMP,       target: U_FETCH};
    endcase
    return w;
  endfunction

  // ddram address; anything off the 2x16 grid goes to the home address
  function automatic logic [7:0] cursor_addr(logic [7:0] row, logic [7:0] col);
    logic [7:0] a;
    if (col == 8'd0 || col > LAST_COL) begin
      a = ADDR_ROW1;
    end else if (row == 8'd1) begin
      a = ADDR_ROW1 + col - 8'd1;
    end else if (row == 8'd2) begin
      a = ADDR_ROW2 + col - 8'd1;
    end else begin
      a = ADDR_ROW1;
    end
    return a;
  endfunction

endpackage

/* rtl/char_lcd_write_sequencer.sv */
// Character LCD write sequencer for an HD44780-style parallel bus.
// A request (operation, value, row, col) is taken on in_valid/in_ready; the
// block answers with one or more strobe events on out_valid/out_ready, each
// giving bus_data, reg_select, wait_ms and last (set on the final event).
// bus_mode is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, as the block does not enforce this. 0 gives one
// strobe per byte, 1 gives a high then a low nibble strobe. A byte request
// passes the fetch step, which takes it, a load step, a high-nibble step and
// a low-nibble step, and is then back at fetch in either mode (the
// high-nibble step puts out no strobe on the 8-bit bus). A number runs
// through a radix-10 long divider that takes four bits a cycle: for each
// digit, one divide step per four bits of NUMBER_WIDTH, then a push step,
// followed by one pop, one high and one low step per digit.
// in_ready is high only while the microprogram sits at its fetch step, so
// one request is in flight at a time. Each result lands in an output
// register; a stalled receiver holds the sequencer at its emit step.
// Operations 5 to 7 are taken and dropped without any event.
// Reset (synchronous, active high) returns to fetch, empties the output
// register and sets bus_mode to eight-bit.
module char_lcd_write_sequencer #(
  parameter int MAX_DIGITS   = 10,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] value,
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  bus_data,
  output logic        reg_select,
  output logic [3:0]  wait_ms,
  output logic        last
);

  localparam int DIV_W  = ((NUMBER_WIDTH + 3) / 4) * 4;
  localparam int STEPS  = DIV_W / 4;
  localparam int STEP_W = $clog2(STEPS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int LOAD_W = (NUMBER_WIDTH < 32) ? NUMBER_WIDTH : 32;

  clws_pkg::upc_t   pc;
  clws_pkg::upc_t   pc_next;
  clws_pkg::uword_t uw;

  logic              bus_mode;
  logic [7:0]        byte_q;
  logic [7:0]        cur_q;
  logic              rs_q;
  logic              clr_q;
  logic [DIV_W-1:0]  num;
  logic [3:0]        rem;
  logic [STEP_W-1:0] dstep;
  logic [CNT_W-1:0]  dcount;
  logic [CNT_W-1:0]  dcount_dec;
  logic [3:0]        digits [MAX_DIGITS];

  logic accept_in;
  logic out_free;
  logic emit_hi;
  logic emit_lo;
  logic hold;
  logic more_digits;
  logic div_more;
  logic digit_more;

  logic [3:0] div_q;
  logic [3:0] div_rem;

  assign uw = clws_pkg::ucode(pc);

  // handshake and emit control
  always_comb begin
    in_ready    = (uw.act == clws_pkg::A_FETCH);
    accept_in   = in_valid && in_ready;
    out_free    = !out_valid || out_ready;
    emit_hi     = (uw.act == clws_pkg::A_EMIT_HI) && bus_mode && out_free;
    emit_lo     = (uw.act == clws_pkg::A_EMIT_LO) && out_free;
    hold        = ((uw.act == clws_pkg::A_EMIT_HI) && bus_mode && !out_free) ||
                  ((uw.act == clws_pkg::A_EMIT_LO) && !out_free);
    more_digits = (dcount != '0);
    div_more    = (dstep != STEP_W'(STEPS - 1));
    digit_more  = (num != '0) && (dcount != CNT_W'(MAX_DIGITS - 1));
    dcount_dec  = dcount - CNT_W'(1);
  end

  // four bits of long division by ten, msb first
  always_comb begin
    logic [4:0] r5;
    logic [3:0] r;
    r     = rem;
    div_q = '0;
    for (int i = 0; i < 4; i++) begin
      r5 = {r, num[DIV_W-1-i]};
      if (r5 >= clws_pkg::RADIX) begin
        r5 = r5 - clws_pkg::RADIX;
        div_q[3-i] = 1'b1;
      end
      r = r5[3:0];
    end
    div_rem = r;
  end

  // sequencer next address
  always_comb begin
    pc_next = pc + clws_pkg::upc_t'(1);
    case (uw.cond)
      clws_pkg::C_NEXT:  pc_next = pc + clws_pkg::upc_t'(1);
      clws_pkg::C_JUMP:  pc_next = uw.target;
      clws_pkg::C_DISPATCH: begin
        pc_next = pc;
        if (accept_in) begin
          case (operation)
            clws_pkg::OP_COMMAND: pc_next = clws_pkg::U_CMD;
            clws_pkg::OP_CHAR:    pc_next = clws_pkg::U_CHR;
            clws_pkg::OP_CLEAR:   pc_next = clws_pkg::U_CLR;
            clws_pkg::OP_CURSOR:  pc_next = clws_pkg::U_CUR;
            clws_pkg::OP_NUMBER:  pc_next = clws_pkg::U_NUM;
            default:              pc_next = clws_pkg::U_FETCH;
          endcase
        end
      end
      clws_pkg::C_DIV_MORE:
        pc_next = div_more ? uw.target : pc + clws_pkg::upc_t'(1);
      clws_pkg::C_DIGIT_MORE:
        pc_next = digit_more ? uw.target : pc + clws_pkg::upc_t'(1);
      clws_pkg::C_RETURN:
        pc_next = more_digits ? uw.target : clws_pkg::U_FETCH;
      default: pc_next = clws_pkg::U_FETCH;
    endcase
    if (hold) begin
      pc_next = pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= clws_pkg::U_FETCH;
      bus_mode <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        bus_mode <= cfg_data;
      end
    end
  end

  // datapath driven by the current control word
  always_ff @(posedge clk) begin
    if (rst) begin
      dcount <= '0;
    end else begin
      case (uw.act)
        clws_pkg::A_FETCH: begin
          dcount <= '0;
          if (accept_in) begin
            byte_q <= value[7:0];
            num    <= DIV_W'(value[LOAD_W-1:0]);
            cur_q  <= clws_pkg::cursor_addr(row, col);
          end
        end
        clws_pkg::A_LD_CMD: begin
          rs_q  <= 1'b0;
          clr_q <= 1'b0;
        end
        clws_pkg::A_LD_CHR: begin
          rs_q  <= 1'b1;
          clr_q <= 1'b0;
        end
        clws_pkg::A_LD_CLR: begin
          byte_q <= clws_pkg::CMD_CLEAR;
          rs_q   <= 1'b0;
          clr_q  <= 1'b1;
        end
        clws_pkg::A_LD_CUR: begin
          byte_q <= cur_q;
          rs_q   <= 1'b0;
          clr_q  <= 1'b0;
        end
        clws_pkg::A_LD_NUM: begin
          rem   <= '0;
          dstep <= '0;
          rs_q  <= 1'b1;
          clr_q <= 1'b0;
        end
        clws_pkg::A_DIV: begin
          num   <= {num[DIV_W-5:0], div_q};
          rem   <= div_rem;
          dstep <= dstep + STEP_W'(1);
        end
        clws_pkg::A_PUSH: begin
          digits[dcount[IDX_W-1:0]] <= rem;
          dcount <= dcount + CNT_W'(1);
          rem    <= '0;
          dstep  <= '0;
        end
        clws_pkg::A_POP: begin
          byte_q <= clws_pkg::ASCII_ZERO + {4'b0, digits[dcount_dec[IDX_W-1:0]]};
          dcount <= dcount_dec;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_hi || emit_lo) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_hi) begin
      bus_data   <= {4'b0, byte_q[7:4]};
      reg_select <= rs_q;
      wait_ms    <= clws_pkg::WAIT_STROBE;
      last       <= 1'b0;
    end else if (emit_lo) begin
      bus_data   <= bus_mode ? {4'b0, byte_q[3:0]} : byte_q;
      reg_select <= rs_q;
      wait_ms    <= clr_q ? clws_pkg::WAIT_CLEAR_LAST : clws_pkg::WAIT_BYTE;
      last       <= !more_digits;
    end
  end

`ifndef ASSERT_OFF
  a_dcount_range: assert property (@(posedge clk) disable iff (rst)
    dcount <= CNT_W'(MAX_DIGITS))
    else $error("digit count past its limit");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation <= clws_pkg::OP_NUMBER) |=> !in_ready)
    else $error("new request taken before the current one started");

  a_no_fetch_midway: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |-> !in_ready)
    else $error("fetch step reached with a request still unfinished");
`endif

endmodule

/* tb/testbench.sv */
module testbench;

  localparam logic [3:0] STROBE_WAIT = 4'd2;
  localparam logic [3:0] BYTE_WAIT = 4'd3;
  localparam logic [3:0] CLEAR_EXTRA = 4'd10;
  localparam logic [3:0] NO_EXTRA = 4'd0;
  localparam logic [7:0] CLEAR_CMD = 8'h01;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DISPLAY_COLS = 8'd16;
  localparam int DIGITS_MAX = 10;
  localparam int DECIMAL_BASE = 10;
  localparam logic MODE_8BIT = 1'b0;
  localparam logic MODE_4BIT = 1'b1;
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA = 1'b1;
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES = 160;
  localparam int HOLD_CYCLES = 400;
  localparam int RUN_LIMIT = 12_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic [3:0] wait_ms;
    logic       last;
  } lcd_strobe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [31:0] value = '0;
  logic [7:0]  row = '0;
  logic [7:0]  col = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  bus_data;
  logic        reg_select;
  logic [3:0]  wait_ms;
  logic        last;

  lcd_strobe_t strobes_due[$];
  logic        four_bit_mode = MODE_8BIT;
  int          errors = 0;
  int          requests_sent = 0;
  int          ignored_sent = 0;
  int          strobes_checked = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;

  char_lcd_write_sequencer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .value(value),
    .row(row),
    .col(col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .bus_data(bus_data),
    .reg_select(reg_select),
    .wait_ms(wait_ms),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] ddram_address(input logic [7:0] r, input logic [7:0] c);
    logic [7:0] addr;
    addr = clws_pkg::ADDR_ROW1;
    if (c != 8'd0 && c <= DISPLAY_COLS) begin
      if (r == 8'd1) addr = clws_pkg::ADDR_ROW1 + c - 8'd1;
      else if (r == 8'd2) addr = clws_pkg::ADDR_ROW2 + c - 8'd1;
    end
    return addr;
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic rs, input logic [3:0] extra);
    if (four_bit_mode) begin
      strobes_due.push_back('{data: {4'd0, b[7:4]}, rs: rs, wait_ms: STROBE_WAIT, last: 1'b0});
      strobes_due.push_back('{data: {4'd0, b[3:0]}, rs: rs, wait_ms: BYTE_WAIT + extra,
                              last: 1'b0});
    end else begin
      strobes_due.push_back('{data: b, rs: rs, wait_ms: BYTE_WAIT + extra, last: 1'b0});
    end
  endfunction

  function automatic void predict_strobes(input logic [2:0] op, input logic [31:0] v,
                                          input logic [7:0] r, input logic [7:0] c);
    logic [31:0] num;
    logic [3:0]  digit[DIGITS_MAX];
    int          cnt;
    int          base;
    base = strobes_due.size();
    case (op)
      clws_pkg::OP_COMMAND: add_byte(v[7:0], RS_INSTR, NO_EXTRA);
      clws_pkg::OP_CHAR:    add_byte(v[7:0], RS_DATA, NO_EXTRA);
      clws_pkg::OP_CLEAR:   add_byte(CLEAR_CMD, RS_INSTR, CLEAR_EXTRA);
      clws_pkg::OP_CURSOR:  add_byte(ddram_address(r, c), RS_INSTR, NO_EXTRA);
      clws_pkg::OP_NUMBER: begin
        num = v;
        cnt = 0;
        if (num == 0) begin
          digit[0] = 4'd0;
          cnt = 1;
        end else begin
          // least significant digit first, sent in reverse
          while (num != 0 && cnt < DIGITS_MAX) begin
            digit[cnt] = 4'(num % DECIMAL_BASE);
            num = num / DECIMAL_BASE;
            cnt++;
          end
        end
        for (int i = cnt - 1; i >= 0; i--) add_byte(DIGIT_ZERO + digit[i], RS_DATA, NO_EXTRA);
      end
      default: ;
    endcase
    if (strobes_due.size() > base) strobes_due[strobes_due.size() - 1].last = 1'b1;
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    lcd_strobe_t want;
    if (!rst && out_valid && out_ready) begin
      strobes_checked++;
      if (strobes_due.size() == 0) begin
        errors++;
        $display("%0t: strobe with none expected: data=%h rs=%b wait=%0d last=%b",
                 $time, bus_data, reg_select, wait_ms, last);
      end else begin
        want = strobes_due.pop_front();
        if (bus_data !== want.data || reg_select !== want.rs ||
            wait_ms !== want.wait_ms || last !== want.last) begin
          errors++;
          $display({"%0t: strobe mismatch: expected data=%h rs=%b wait=%0d last=%b,",
                    " got data=%h rs=%b wait=%0d last=%b"},
                   $time, want.data, want.rs, want.wait_ms, want.last,
                   bus_data, reg_select, wait_ms, last);
        end
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [31:0] v,
                              input logic [7:0] r, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    value <= v;
    row <= r;
    col <= c;
    do @(posedge clk); while (!in_ready);
    predict_strobes(op, v, r, c);
    if (op > clws_pkg::OP_NUMBER) ignored_sent++;
    else requests_sent++;
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (strobes_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_bus_mode(input logic m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    four_bit_mode = m;
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int          pick;
    logic [2:0]  op;
    logic [31:0] v;
    logic [7:0]  r;
    logic [7:0]  c;
    pick = $urandom_range(99);
    v = $urandom;
    r = 8'($urandom);
    c = 8'($urandom);
    if (pick < 20) op = clws_pkg::OP_COMMAND;
    else if (pick < 42) op = clws_pkg::OP_CHAR;
    else if (pick < 50) op = clws_pkg::OP_CLEAR;
    else if (pick < 70) begin
      op = clws_pkg::OP_CURSOR;
      // mostly on-screen positions
      if ($urandom_range(3) != 0) begin
        r = 8'($urandom_range(1, 2));
        c = 8'($urandom_range(1, DISPLAY_COLS));
      end
    end else if (pick < 94) begin
      op = clws_pkg::OP_NUMBER;
      case ($urandom_range(3))
        0: v = '0;
        1: v = $urandom_range(999);
        2: v = v >> $urandom_range(31);
        default: ;
      endcase
    end else begin
      op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end
    send_request(op, v, r, c);
  endtask

  task automatic run_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                                  input int count);
    int target;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = requests_sent + count;
    while (requests_sent < target) begin
      // now and then let the block run dry before the next request
      if ($urandom_range(29) == 0) wait_drained(1);
      random_request();
    end
  endtask

  task automatic test_directed_bytes();
    send_idle_pct = 20;
    recv_idle_pct = 30;
    send_request(clws_pkg::OP_COMMAND, 32'h0000_0000, 8'd0, 8'd0);
    send_request(clws_pkg::OP_COMMAND, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_request(clws_pkg::OP_CHAR, 32'h1234_5641, 8'd1, 8'd1);
    send_request(clws_pkg::OP_CHAR, 32'h0000_00FF, 8'd2, 8'd16);
    send_request(clws_pkg::OP_CLEAR, 32'hDEAD_BEEF, 8'd7, 8'd9);
    send_request(clws_pkg::OP_CURSOR, '0, 8'd1, 8'd1);
    send_request(clws_pkg::OP_CURSOR, '0, 8'd2, 8'd16);
    send_request(clws_pkg::OP_CURSOR, '0, 8'd0, 8'd5);
    send_request(clws_pkg::OP_CURSOR, '0, 8'd3, 8'd9);
    send_request(clws_pkg::OP_CURSOR, '0, 8'd1, 8'd0);
    send_request(clws_pkg::OP_CURSOR, '0, 8'd2, 8'd17);
    send_request(clws_pkg::OP_CURSOR, '0, 8'hFF, 8'hFF);
    send_request(clws_pkg::OP_NUMBER, 32'd0, 8'd0, 8'd0);
    send_request(clws_pkg::OP_NUMBER, 32'hFFFF_FFFF, 8'd0, 8'd0);
    send_request(clws_pkg::OP_NUMBER, 32'd9, 8'd0, 8'd0);
    send_request(OP_SPARE_A, $urandom, 8'd1, 8'd1);
    send_request(OP_SPARE_B, $urandom, 8'd2, 8'd3);
    send_request(OP_SPARE_C, $urandom, 8'hFF, 8'h00);
  endtask

  task automatic test_directed_nibbles();
    wait_drained(SETTLE_CYCLES);
    write_bus_mode(MODE_4BIT);
    send_request(clws_pkg::OP_COMMAND, 32'h0000_00A5, 8'd0, 8'd0);
    send_request(clws_pkg::OP_CHAR, 32'h0000_003C, 8'd0, 8'd0);
    send_request(clws_pkg::OP_CLEAR, '0, 8'd0, 8'd0);
    send_request(clws_pkg::OP_CURSOR, '0, 8'd2, 8'd8);
    send_request(clws_pkg::OP_NUMBER, 32'd1234567890, 8'd0, 8'd0);
    send_request(clws_pkg::OP_NUMBER, 32'd0, 8'd0, 8'd0);
  endtask

  task automatic test_random_traffic();
    wait_drained(SETTLE_CYCLES);
    write_bus_mode(MODE_8BIT);
    run_random_phase(35, 58, 40);
    wait_drained(SETTLE_CYCLES);
    write_bus_mode(MODE_4BIT);
    run_random_phase(58, 35, 40);
    wait_drained(SETTLE_CYCLES);
    write_bus_mode(1'($urandom_range(1)));
    run_random_phase(0, 0, 40);
  endtask

  // receiver stops for a long while, sender keeps offering back to back
  task automatic test_backpressure();
    wait_drained(SETTLE_CYCLES);
    write_bus_mode(MODE_4BIT);
    send_idle_pct = 0;
    recv_idle_pct = 10;
    recv_hold = HOLD_CYCLES;
    repeat (12) random_request();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_bytes();
    test_directed_nibbles();
    test_random_traffic();
    test_backpressure();
    wait_drained(DRAIN_CYCLES);
    $display("run covered %0d display requests and %0d dropped ones on both bus widths",
             requests_sent, ignored_sent);
    $display("%0d strobe events checked, %0d mismatches", strobes_checked, errors);
    if (errors == 0) begin
      $display("char_lcd_write_sequencer regression: pass");
    end else begin
      $display("char_lcd_write_sequencer regression: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d strobe events still expected", strobes_due.size());
    $display("char_lcd_write_sequencer regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/clws_pkg.sv
rtl/char_lcd_write_sequencer.sv
tb/testbench.sv
